// File: rtl/assert_macros.svh
// assertion macros used by the top level rtl file of the aging table
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ppat_pkg.sv
// shared types and constants of the peer presence aging table
// no dependencies
package ppat_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int KEY_BITS      = 32;
    localparam int TIMER_BITS    = 8;
    localparam int STATUS_BITS   = 3;
    localparam int COUNT_BITS    = 5;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [TIMER_BITS-1:0] LIFETIME_RESET = 8'd10;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_REFRESHED = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_OWN       = 3'd3,
        ST_TICK      = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LIFETIME = 1'b0,
        REG_OWN_KEY  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_INSERT,
        FSM_DONE
    } fsm_t;

    // outcome of aging one entry
    typedef struct packed {
        logic match;
        logic expire;
        logic free;
        logic wr;
    } entry_upd_t;

endpackage

// File: rtl/ppat_req_if.sv
// request channel of the aging table: op and announced key
// depends on ppat_pkg
interface ppat_req_if;
    logic                          valid;
    logic                          ready;
    logic [0:0]                    op;
    logic [ppat_pkg::KEY_BITS-1:0] peer_key;

    modport source (output valid, output op, output peer_key, input ready);
    modport sink   (input valid, input op, input peer_key, output ready);
endinterface

// File: rtl/ppat_res_if.sv
// result channel of the aging table: status and counts
// depends on ppat_pkg
interface ppat_res_if;
    logic                             valid;
    logic                             ready;
    logic [ppat_pkg::STATUS_BITS-1:0] status;
    logic [ppat_pkg::COUNT_BITS-1:0]  expired_count;
    logic [ppat_pkg::COUNT_BITS-1:0]  live_count;

    modport source (output valid, output status, output expired_count,
                    output live_count, input ready);
    modport sink   (input valid, input status, input expired_count,
                    input live_count, output ready);
endinterface

// File: rtl/ppat_ram.sv
// generic single port write, single port read ram with registered read
// no dependencies
module ppat_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ppat_entry_upd.sv
// refresh and aging of one table entry read back from the ram
// depends on ppat_pkg
module ppat_entry_upd #(
    parameter int KEY_W = 32
) (
    input  logic                            entry_valid,
    input  logic [KEY_W-1:0]                entry_key,
    input  logic [ppat_pkg::TIMER_BITS-1:0] entry_timer,
    input  logic [KEY_W-1:0]                req_key,
    input  logic                            tick,
    input  logic [ppat_pkg::TIMER_BITS-1:0] lifetime,
    output ppat_pkg::entry_upd_t            upd,
    output logic [ppat_pkg::TIMER_BITS-1:0] new_timer
);

    logic [ppat_pkg::TIMER_BITS-1:0] timer_eff;

    always_comb
    begin
        upd.match  = entry_valid && !tick && (entry_key == req_key);
        // refresh comes before aging
        timer_eff  = upd.match ? lifetime : entry_timer;
        upd.expire = entry_valid && (timer_eff == '0);
        upd.free   = !entry_valid || upd.expire;
        upd.wr     = entry_valid && (timer_eff != '0);
        new_timer  = timer_eff - 1'b1;
    end

endmodule

// File: rtl/peer_presence_aging_table.sv
// top level of the peer presence aging table
// depends on ppat_pkg, ppat_req_if, ppat_res_if, ppat_ram, ppat_entry_upd, assert_macros.svh
//
//   channel | dir | carries
//   --------+-----+----------------------------------------------
//   req     | in  | op (announce or tick), peer_key
//   res     | out | status, expired_count, live_count
//   cfg     | in  | cfg_we, cfg_index, cfg_data (lifetime, own_key)
//
// a scanned request (announcement or tick) passes through these steps, one request at a time: accept,
// one ram read per entry, last read data, scan drained, insert, result load; an own-key
// request skips the scan and goes from accept straight to the result load
// reset clears the valid flags and the live count at once, no clearing pass
// a new request is taken while the previous result still waits in res
// a stalled res holds the finished result and the block waits before loading the next
`include "assert_macros.svh"

module peer_presence_aging_table #(
    parameter int TABLE_DEPTH = ppat_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = ppat_pkg::KEY_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ppat_req_if.sink                           req,
    ppat_res_if.source                         res,
    input  logic                               cfg_we,
    input  logic [ppat_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ppat_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    // stored key width: keys compare on their low KEY_WIDTH bits of the 32 bit port, capped at 32
    localparam int SK     = (KEY_WIDTH < ppat_pkg::KEY_BITS) ? KEY_WIDTH : ppat_pkg::KEY_BITS;
    localparam int TW     = ppat_pkg::TIMER_BITS;
    localparam int WORD_W = SK + TW;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // control state
    ppat_pkg::fsm_t   state_reg, state_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             found_reg, found_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] expired_reg, expired_next;
    logic [CNT_W-1:0] live_count_reg, live_count_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic             res_valid_reg, res_valid_next;

    // configuration
    logic [TW-1:0]                        lifetime_reg;
    logic [ppat_pkg::CFG_DATA_BITS-1:0]   own_key_reg;

    // request and result payload
    logic                                 tick_reg, tick_next;
    logic [SK-1:0]                        key_reg, key_next;
    ppat_pkg::status_t                    status_reg, status_next;
    logic [ppat_pkg::STATUS_BITS-1:0]     res_status_reg, res_status_next;
    logic [ppat_pkg::COUNT_BITS-1:0]      res_expired_reg, res_expired_next;
    logic [ppat_pkg::COUNT_BITS-1:0]      res_live_reg, res_live_next;

    // ram ports
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [WORD_W-1:0] mem_rdata;

    // entry update
    ppat_pkg::entry_upd_t upd;
    logic [TW-1:0]        upd_timer;
    logic [CNT_W-1:0]     live_tmp;
    logic                 own_hit;

    // key and timer of every slot, valid flags stay in flops
    ppat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // ages the entry whose read data arrives this cycle
    ppat_entry_upd #(
        .KEY_W (SK)
    ) u_upd (
        .entry_valid (valid_reg[pend_idx_reg]),
        .entry_key   (mem_rdata[WORD_W-1:TW]),
        .entry_timer (mem_rdata[TW-1:0]),
        .req_key     (key_reg),
        .tick        (tick_reg),
        .lifetime    (lifetime_reg),
        .upd         (upd),
        .new_timer   (upd_timer)
    );

    assign own_hit   = !req.op[0] && (req.peer_key[SK-1:0] == own_key_reg[SK-1:0]);
    assign req.ready = (state_reg == ppat_pkg::FSM_IDLE);
    assign mem_re    = (state_reg == ppat_pkg::FSM_SCAN) && (rd_cnt_reg != DEPTH_CNT);

    assign res.valid         = res_valid_reg;
    assign res.status        = res_status_reg;
    assign res.expired_count = res_expired_reg;
    assign res.live_count    = res_live_reg;

    always_comb
    begin
        state_next       = state_reg;
        rd_cnt_next      = rd_cnt_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        found_next       = found_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        expired_next     = expired_reg;
        live_count_next  = live_count_reg;
        valid_next       = valid_reg;
        tick_next        = tick_reg;
        key_next         = key_reg;
        status_next      = status_reg;
        res_status_next  = res_status_reg;
        res_expired_next = res_expired_reg;
        res_live_next    = res_live_reg;
        res_valid_next   = res_valid_reg;
        live_tmp         = live_count_reg - expired_reg;
        mem_we           = 1'b0;
        mem_waddr        = pend_idx_reg;
        // write back keeps the key, stores the aged timer
        mem_wdata        = {mem_rdata[WORD_W-1:TW], upd_timer};

        // result taken downstream
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ppat_pkg::FSM_IDLE:
            begin
                if (req.valid)
                begin
                    tick_next       = req.op[0];
                    key_next        = req.peer_key[SK-1:0];
                    expired_next    = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    rd_cnt_next     = '0;
                    pend_next       = 1'b0;
                    if (own_hit)
                    begin
                        // ignored entirely, no aging
                        status_next = ppat_pkg::ST_OWN;
                        state_next  = ppat_pkg::FSM_DONE;
                    end
                    else
                    begin
                        state_next = ppat_pkg::FSM_SCAN;
                    end
                end
            end

            ppat_pkg::FSM_SCAN:
            begin
                // issue side: one read per entry in slot order
                pend_next     = (rd_cnt_reg != DEPTH_CNT);
                pend_idx_next = rd_cnt_reg[IDX_W-1:0];
                if (rd_cnt_reg != DEPTH_CNT)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                // modify and write back the entry read last cycle
                if (pend_reg)
                begin
                    found_next = found_reg || upd.match;
                    if (upd.expire)
                    begin
                        valid_next[pend_idx_reg] = 1'b0;
                        expired_next             = expired_reg + 1'b1;
                    end
                    if (upd.wr)
                    begin
                        mem_we = 1'b1;
                    end
                    // lowest slot free after this step's removals
                    if (upd.free && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                end
                if (!pend_reg && (rd_cnt_reg == DEPTH_CNT))
                begin
                    state_next = ppat_pkg::FSM_INSERT;
                end
            end

            ppat_pkg::FSM_INSERT:
            begin
                if (tick_reg)
                begin
                    status_next = ppat_pkg::ST_TICK;
                end
                else if (found_reg)
                begin
                    status_next = ppat_pkg::ST_REFRESHED;
                end
                else if (free_found_reg)
                begin
                    // new key keeps the full lifetime this step
                    mem_we                   = 1'b1;
                    mem_waddr                = free_idx_reg;
                    mem_wdata                = {key_reg, lifetime_reg};
                    valid_next[free_idx_reg] = 1'b1;
                    live_tmp                 = live_count_reg - expired_reg + 1'b1;
                    status_next              = ppat_pkg::ST_ADDED;
                end
                else
                begin
                    status_next = ppat_pkg::ST_FULL;
                end
                live_count_next = live_tmp;
                state_next      = ppat_pkg::FSM_DONE;
            end

            ppat_pkg::FSM_DONE:
            begin
                // load the result register once it is free
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next   = 1'b1;
                    res_status_next  = status_reg;
                    res_expired_next = ppat_pkg::COUNT_BITS'(expired_reg);
                    res_live_next    = ppat_pkg::COUNT_BITS'(live_count_reg);
                    state_next       = ppat_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = ppat_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppat_pkg::FSM_IDLE;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            expired_reg    <= '0;
            live_count_reg <= '0;
            valid_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            expired_reg    <= expired_next;
            live_count_reg <= live_count_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // configuration registers, the user must write them only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= ppat_pkg::LIFETIME_RESET;
            own_key_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (ppat_pkg::cfg_reg_t'(cfg_index))
                ppat_pkg::REG_LIFETIME: lifetime_reg <= cfg_data[TW-1:0];
                ppat_pkg::REG_OWN_KEY:  own_key_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        tick_reg        <= tick_next;
        key_reg         <= key_next;
        status_reg      <= status_next;
        res_status_reg  <= res_status_next;
        res_expired_reg <= res_expired_next;
        res_live_reg    <= res_live_next;
    end

    // live count tracks the valid flags between requests
    `ASSERT_ALWAYS(a_live_matches_valid,
        (state_reg != ppat_pkg::FSM_IDLE) || (int'(live_count_reg) == $countones(valid_reg)),
        "live count differs from valid flags")

    // live count never exceeds the table
    `ASSERT_ALWAYS(a_live_bounded, live_count_reg <= DEPTH_CNT, "live count above depth")

    // insert starts only after every entry was read and written back
    `ASSERT_ALWAYS(a_scan_complete,
        (state_reg != ppat_pkg::FSM_INSERT) || (!pend_reg && (rd_cnt_reg == DEPTH_CNT)),
        "insert before scan finished")

    // own key request goes straight to the result
    `ASSERT_NEXT(a_own_skips_scan, req.valid && req.ready && own_hit,
        state_reg == ppat_pkg::FSM_DONE, "own key request entered the scan")

endmodule

// File: tb/tb.sv
// self-checking bench for the peer presence aging table, drives requests and config writes
// depends on ppat_pkg, ppat_req_if, ppat_res_if and peer_presence_aging_table
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES       = ppat_pkg::TABLE_DEPTH_DEF;
    localparam int KEY_POOL      = 20;
    localparam int PHASE_ITEMS   = 110;
    localparam int RANDOM_PHASES = 10;
    // one full scan plus insert and result load, with some margin
    localparam int SETTLE_CYCLES = ppat_pkg::TABLE_DEPTH_DEF + 8;
    localparam int DRAIN_CAP     = 200000;

    // one request as the sender sees it
    typedef struct packed {
        logic                          tick;
        logic [ppat_pkg::KEY_BITS-1:0] key;
    } beacon_t;

    // one result as the table should report it
    typedef struct packed {
        ppat_pkg::status_t               status;
        logic [ppat_pkg::COUNT_BITS-1:0] expired;
        logic [ppat_pkg::COUNT_BITS-1:0] live;
    } outcome_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [ppat_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [ppat_pkg::CFG_DATA_BITS-1:0] cfg_data;

    ppat_req_if req_ch ();
    ppat_res_if res_ch ();

    peer_presence_aging_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the table and its registers
    logic                            known_valid [ENTRIES];
    logic [ppat_pkg::KEY_BITS-1:0]   known_key   [ENTRIES];
    logic [ppat_pkg::TIMER_BITS-1:0] known_ttl   [ENTRIES];
    logic [ppat_pkg::TIMER_BITS-1:0] shadow_lifetime;
    logic [ppat_pkg::KEY_BITS-1:0]   shadow_own_key;

    beacon_t  queued_beacons [$];
    outcome_t awaited_outcomes [$];

    int   idle_pct    = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   fault_count = 0;
    int   reqs_issued = 0;
    int   reqs_taken  = 0;
    logic req_fire    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the table hangs or drops a result
    initial
    begin
        #4_000_000;
        $display("timeout waiting for the table to finish");
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endfunction

    // ages the shadow table by one request and returns what the block should report
    function automatic outcome_t table_outcome(input logic is_tick,
                                               input logic [ppat_pkg::KEY_BITS-1:0] key);
        outcome_t verdict;
        logic     hit;
        logic     placed;
        int       removed;
        int       occupied;
        hit      = 1'b0;
        placed   = 1'b0;
        removed  = 0;
        occupied = 0;
        if (!is_tick && key == shadow_own_key)
        begin
            // own key: no refresh, no aging
            verdict.status = ppat_pkg::ST_OWN;
        end
        else
        begin
            // refresh happens before aging, so a refreshed entry ends at lifetime - 1, or goes if the lifetime is zero
            if (!is_tick)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (known_valid[i] && known_key[i] == key)
                    begin
                        known_ttl[i] = shadow_lifetime;
                        hit          = 1'b1;
                    end
                end
            end
            // entries already at zero go, the rest count down
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (known_valid[i])
                begin
                    if (known_ttl[i] == '0)
                    begin
                        known_valid[i] = 1'b0;
                        removed++;
                    end
                    else
                    begin
                        known_ttl[i] = known_ttl[i] - 1'b1;
                    end
                end
            end
            if (is_tick)
            begin
                verdict.status = ppat_pkg::ST_TICK;
            end
            else if (hit)
            begin
                verdict.status = ppat_pkg::ST_REFRESHED;
            end
            else
            begin
                // insert into the lowest free slot, a slot freed just now counts
                verdict.status = ppat_pkg::ST_FULL;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!placed && !known_valid[i])
                    begin
                        known_valid[i] = 1'b1;
                        known_key[i]   = key;
                        known_ttl[i]   = shadow_lifetime;
                        placed         = 1'b1;
                        verdict.status = ppat_pkg::ST_ADDED;
                    end
                end
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (known_valid[i])
            begin
                occupied++;
            end
        end
        verdict.expired = removed[ppat_pkg::COUNT_BITS-1:0];
        verdict.live    = occupied[ppat_pkg::COUNT_BITS-1:0];
        return verdict;
    endfunction

    // request driver: pops the next request once the current one is taken
    always @(negedge clk)
    begin : drive_requests
        beacon_t next_beacon;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (queued_beacons.size() > 0)
            begin
                next_beacon = queued_beacons.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.op       <= next_beacon.tick;
                req_ch.peer_key <= next_beacon.key;
                reqs_issued++;
                // maybe hold back the following request for a burst
                if ($urandom_range(0, 99) < idle_pct)
                begin
                    gap_left = $urandom_range(1, 14);
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: ready with random stall bursts
    always @(negedge clk)
    begin : drive_ready
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 399) < idle_pct)
            begin
                stall_left = $urandom_range(1, 14);
            end
        end
    end

    // monitor: checks each result against the oldest expectation, then predicts new requests
    always @(posedge clk)
    begin : watch_channels
        outcome_t want;
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                log_fault($sformatf("result status %0d expired %0d live %0d with none awaited",
                                    res_ch.status, res_ch.expired_count, res_ch.live_count));
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                if (res_ch.status !== want.status)
                begin
                    log_fault($sformatf("status expected %0d got %0d",
                                        want.status, res_ch.status));
                end
                if (res_ch.expired_count !== want.expired)
                begin
                    log_fault($sformatf("expired_count expected %0d got %0d",
                                        want.expired, res_ch.expired_count));
                end
                if (res_ch.live_count !== want.live)
                begin
                    log_fault($sformatf("live_count expected %0d got %0d",
                                        want.live, res_ch.live_count));
                end
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            awaited_outcomes.insert(awaited_outcomes.size(),
                                    table_outcome(req_ch.op[0], req_ch.peer_key));
            reqs_taken++;
        end
    end

    task automatic announce(input logic [ppat_pkg::KEY_BITS-1:0] key);
        beacon_t pending;
        pending.tick = 1'b0;
        pending.key  = key;
        queued_beacons.insert(queued_beacons.size(), pending);
    endtask

    // tick carries a random key that the table must ignore
    task automatic tick_once();
        beacon_t pending;
        pending.tick = 1'b1;
        pending.key  = $urandom();
        queued_beacons.insert(queued_beacons.size(), pending);
    endtask

    // config writes only happen with the table idle, so the shadow follows at once
    task automatic program_reg(input ppat_pkg::cfg_reg_t sel,
                               input logic [ppat_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        if (sel == ppat_pkg::REG_LIFETIME)
        begin
            shadow_lifetime = value[ppat_pkg::TIMER_BITS-1:0];
        end
        else
        begin
            shadow_own_key = value[ppat_pkg::KEY_BITS-1:0];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender holds until every request is taken and every result is back
    task automatic wait_table_quiet();
        int waited;
        waited = 0;
        while ((queued_beacons.size() != 0 || reqs_issued != reqs_taken ||
                awaited_outcomes.size() != 0) && waited < DRAIN_CAP)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [ppat_pkg::KEY_BITS-1:0] key_pool [KEY_POOL];
        logic [ppat_pkg::KEY_BITS-1:0] own_pick;
        int                            pick;
        int                            life_pick;

        // every input known from time zero
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = ppat_pkg::REG_LIFETIME;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.op       = '0;
        req_ch.peer_key = '0;
        res_ch.ready    = 1'b0;

        // shadow matches the block right after reset
        for (int i = 0; i < ENTRIES; i++)
        begin
            known_valid[i] = 1'b0;
            known_key[i]   = '0;
            known_ttl[i]   = '0;
        end
        shadow_lifetime = ppat_pkg::LIFETIME_RESET;
        shadow_own_key  = '0;

        idle_pct = 25;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset registers: own key zero is ignored, adds, a refresh, a tick
        announce('0);
        announce('1);
        announce(32'h0000_0001);
        announce('1);
        tick_once();
        wait_table_quiet();

        // longest lifetime, own key equal to a key still in the table
        program_reg(ppat_pkg::REG_LIFETIME, 32'd255);
        program_reg(ppat_pkg::REG_OWN_KEY, 32'hFFFF_FFFF);
        announce('1);
        announce(32'h0000_0001);
        for (int k = 0; k < 16; k++)
        begin
            announce(32'h8000_0000 >> k);
        end
        // last one above finds the table full, then a refresh while full
        announce(32'h0000_0001);
        wait_table_quiet();

        // lifetime zero: a refresh removes at once, an insert goes at the next request
        program_reg(ppat_pkg::REG_LIFETIME, 32'd0);
        program_reg(ppat_pkg::REG_OWN_KEY, 32'h5A5A_5A5A);
        announce(32'h0000_0001);
        announce(32'h7E57_0001);
        tick_once();
        announce(32'h5A5A_5A5A);
        wait_table_quiet();

        // random phases, each with fresh registers and a fresh set of peers
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int j = 0; j < KEY_POOL; j++)
            begin
                key_pool[j] = $urandom();
            end
            case (ph)
                0:       life_pick = 255;
                1:       life_pick = 1;
                2:       life_pick = 0;
                3:       life_pick = $urandom_range(100, 255);
                default: life_pick = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 3))
                0:       own_pick = key_pool[0];
                1:       own_pick = $urandom();
                2:       own_pick = '0;
                default: own_pick = '1;
            endcase
            // no idling at all in the closing phase
            idle_pct = (ph == RANDOM_PHASES - 1) ? 0 : $urandom_range(5, 40);
            program_reg(ppat_pkg::REG_LIFETIME, life_pick);
            program_reg(ppat_pkg::REG_OWN_KEY, own_pick);
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    tick_once();
                end
                else if (pick < 30)
                begin
                    announce(shadow_own_key);
                end
                else if (pick < 85)
                begin
                    announce(key_pool[$urandom_range(0, KEY_POOL - 1)]);
                end
                else
                begin
                    announce($urandom());
                end
            end
            wait_table_quiet();
        end

        if (awaited_outcomes.size() != 0)
        begin
            log_fault($sformatf("%0d results never arrived", awaited_outcomes.size()));
        end
        if (fault_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ppat_pkg.sv
rtl/ppat_req_if.sv
rtl/ppat_res_if.sv
rtl/ppat_ram.sv
rtl/ppat_entry_upd.sv
rtl/peer_presence_aging_table.sv
tb/tb.sv
